// ----- sv/wsp_pkg.sv -----
// Shared types, codes and constants for the WAV stream parser.
`timescale 1ns / 1ps
`default_nettype none
package wsp_pkg;

    typedef enum logic [2:0] {
        FR_RIFF,
        FR_SUBHDR,
        FR_FMT,
        FR_SKIP,
        FR_DATA,
        FR_DIV,
        FR_DONE
    } t_front_state;

    typedef enum logic {
        BK_IDLE,
        BK_NORM
    } t_back_state;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_BAD_TAG    = 3'd0;
    localparam logic [2:0] ERR_FMT_SHORT  = 3'd1;
    localparam logic [2:0] ERR_ZERO_FRAME = 3'd2;
    localparam logic [2:0] ERR_UNSUPP     = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd4;

    localparam logic [1:0] FMT_INT16   = 2'd0;
    localparam logic [1:0] FMT_INT24   = 2'd1;
    localparam logic [1:0] FMT_FLOAT32 = 2'd2;

    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam logic [15:0] CODE_PCM   = 16'd1;
    localparam logic [15:0] CODE_FLOAT = 16'd3;

    localparam logic [7:0] EXP_INT16 = 8'd135;
    localparam logic [7:0] EXP_INT24 = 8'd127;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  fmt;
        logic [2:0]  err;
        logic [31:0] word;
        logic [15:0] chan;
        logic [30:0] frame;
        logic        eoa;
        logic [31:0] rate;
        logic [15:0] chan_count;
        logic [30:0] total;
    } t_cmd;

    function automatic logic [7:0] riff_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h52;
            4'd1:    v = 8'h49;
            4'd2:    v = 8'h46;
            4'd3:    v = 8'h46;
            4'd8:    v = 8'h57;
            4'd9:    v = 8'h41;
            4'd10:   v = 8'h56;
            4'd11:   v = 8'h45;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- sv/wsp_front.sv -----
// Byte parser: header decoding, frame count divider and sample assembly.
`timescale 1ns / 1ps
`default_nettype none
module wsp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_first_byte,
    input  wire logic          i_last_byte,
    output logic               o_push,
    output wsp_pkg::t_cmd      o_cmd,
    input  wire logic          i_full
);

    wsp_pkg::t_front_state r_state, n_state, e_state, after_state;
    logic [31:0] r_pos, n_pos, e_pos;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [15:0] r_coding, n_coding, e_coding;
    logic [15:0] r_chan, n_chan, e_chan;
    logic [31:0] r_rate, n_rate, e_rate;
    logic [15:0] r_bits, n_bits, e_bits;
    logic [30:0] r_frames, n_frames;
    logic [30:0] r_fr, n_fr;
    logic [15:0] r_ch, n_ch;
    logic [31:0] r_asm, n_asm;
    logic [1:0]  r_fmt, n_fmt;
    logic [28:0] r_bpf, n_bpf;
    logic [31:0] r_quo, n_quo;
    logic [28:0] r_rem, n_rem;
    logic [5:0]  r_dcnt, n_dcnt;
    logic        r_last_pend, n_last_pend;

    logic        acc;
    logic        div_done;
    logic        bad_tag;
    logic        hdr_done;
    logic [31:0] full_len;
    logic [28:0] bpf;
    logic        bpf_zero;
    logic        fmt_ok;
    logic [1:0]  fmt_sel;
    logic [1:0]  last_idx;
    logic        samp_done;
    logic [31:0] asm_next;
    logic        ch_wrap;
    logic        fr_end;
    logic [29:0] rem2;
    logic        ge;
    logic [31:0] byte_sh;

    assign acc      = i_valid && o_ready;
    assign o_ready  = (r_state != wsp_pkg::FR_DIV) && !i_full;
    assign div_done = (r_dcnt == 6'd32);

    assign e_state  = i_first_byte ? wsp_pkg::FR_RIFF : r_state;
    assign e_pos    = i_first_byte ? 32'd0 : r_pos;
    assign e_coding = i_first_byte ? 16'd0 : r_coding;
    assign e_chan   = i_first_byte ? 16'd0 : r_chan;
    assign e_rate   = i_first_byte ? 32'd0 : r_rate;
    assign e_bits   = i_first_byte ? 16'd0 : r_bits;

    assign bad_tag  = (e_pos < 32'd4 || e_pos >= 32'd8)
                      && (i_data_byte != wsp_pkg::riff_byte(e_pos[3:0]));
    assign hdr_done = (e_pos == 32'd7);
    assign full_len = {i_data_byte, r_len[23:0]};
    assign bpf      = 29'(e_chan) * 29'(e_bits[15:3]);
    assign bpf_zero = (bpf == 29'd0);

    always_comb begin
        fmt_ok  = 1'b1;
        fmt_sel = wsp_pkg::FMT_FLOAT32;
        if (e_coding == wsp_pkg::CODE_FLOAT && e_bits == 16'd32) begin
            fmt_sel = wsp_pkg::FMT_FLOAT32;
        end else if (e_coding == wsp_pkg::CODE_PCM && e_bits == 16'd16) begin
            fmt_sel = wsp_pkg::FMT_INT16;
        end else if (e_coding == wsp_pkg::CODE_PCM && e_bits == 16'd24) begin
            fmt_sel = wsp_pkg::FMT_INT24;
        end else if (e_coding == wsp_pkg::CODE_PCM && e_bits == 16'd32) begin
            fmt_sel = wsp_pkg::FMT_FLOAT32;
        end else begin
            fmt_ok = 1'b0;
        end
    end

    always_comb begin
        case (r_fmt)
            wsp_pkg::FMT_INT16: last_idx = 2'd1;
            wsp_pkg::FMT_INT24: last_idx = 2'd2;
            default:            last_idx = 2'd3;
        endcase
    end

    assign byte_sh   = {24'd0, i_data_byte} << {e_pos[1:0], 3'b000};
    assign samp_done = (e_pos[1:0] == last_idx);
    assign asm_next  = (e_pos[1:0] == 2'd0) ? {24'd0, i_data_byte} : (r_asm | byte_sh);
    assign ch_wrap   = ({1'b0, r_ch} + 17'd1) >= {1'b0, r_chan};
    assign fr_end    = ({1'b0, r_fr} + 32'd1) >= {1'b0, r_frames};

    assign rem2 = {r_rem, r_quo[31]};
    assign ge   = rem2 >= {1'b0, r_bpf};

    always_comb begin
        after_state = e_state;
        case (e_state)
            wsp_pkg::FR_RIFF: begin
                if (bad_tag) begin
                    after_state = wsp_pkg::FR_DONE;
                end else if (e_pos == 32'd11) begin
                    after_state = wsp_pkg::FR_SUBHDR;
                end
            end
            wsp_pkg::FR_SUBHDR: begin
                if (hdr_done) begin
                    if (r_tag == wsp_pkg::TAG_FMT) begin
                        after_state = (full_len < 32'd16) ? wsp_pkg::FR_DONE
                                                          : wsp_pkg::FR_FMT;
                    end else if (r_tag == wsp_pkg::TAG_DATA) begin
                        after_state = (bpf_zero || !fmt_ok) ? wsp_pkg::FR_DONE
                                                            : wsp_pkg::FR_DIV;
                    end else if (full_len != 32'd0) begin
                        after_state = wsp_pkg::FR_SKIP;
                    end
                end
            end
            wsp_pkg::FR_FMT: begin
                if (e_pos == 32'd15) begin
                    after_state = (r_len == 32'd16) ? wsp_pkg::FR_SUBHDR
                                                    : wsp_pkg::FR_SKIP;
                end
            end
            wsp_pkg::FR_SKIP: begin
                if (e_pos <= 32'd1) begin
                    after_state = wsp_pkg::FR_SUBHDR;
                end
            end
            wsp_pkg::FR_DATA: begin
                if (samp_done && ch_wrap && fr_end) begin
                    after_state = wsp_pkg::FR_DONE;
                end
            end
            default: after_state = e_state;
        endcase
    end

    always_comb begin
        n_state = r_state;
        if (r_state == wsp_pkg::FR_DIV) begin
            if (div_done && !i_full) begin
                n_state = (r_last_pend || r_quo[30:0] == 31'd0) ? wsp_pkg::FR_DONE
                                                                : wsp_pkg::FR_DATA;
            end
        end else if (acc) begin
            n_state = (i_last_byte && after_state != wsp_pkg::FR_DIV) ? wsp_pkg::FR_DONE
                                                                      : after_state;
        end
    end

    always_comb begin
        o_push = 1'b0;
        o_cmd  = '0;
        if (r_state == wsp_pkg::FR_DIV) begin
            o_push           = div_done && !i_full;
            o_cmd.kind       = wsp_pkg::KIND_FORMAT;
            o_cmd.rate       = r_rate;
            o_cmd.chan_count = r_chan;
            o_cmd.fmt        = r_fmt;
            o_cmd.total      = r_quo[30:0];
        end else if (acc) begin
            o_cmd.kind = wsp_pkg::KIND_ERROR;
            if (e_state == wsp_pkg::FR_RIFF && bad_tag) begin
                o_push    = 1'b1;
                o_cmd.err = wsp_pkg::ERR_BAD_TAG;
            end else if (e_state == wsp_pkg::FR_SUBHDR && hdr_done
                         && r_tag == wsp_pkg::TAG_FMT && full_len < 32'd16) begin
                o_push    = 1'b1;
                o_cmd.err = wsp_pkg::ERR_FMT_SHORT;
            end else if (e_state == wsp_pkg::FR_SUBHDR && hdr_done
                         && r_tag == wsp_pkg::TAG_DATA && bpf_zero) begin
                o_push    = 1'b1;
                o_cmd.err = wsp_pkg::ERR_ZERO_FRAME;
            end else if (e_state == wsp_pkg::FR_SUBHDR && hdr_done
                         && r_tag == wsp_pkg::TAG_DATA && !fmt_ok) begin
                o_push    = 1'b1;
                o_cmd.err = wsp_pkg::ERR_UNSUPP;
            end else if (e_state == wsp_pkg::FR_DATA && samp_done) begin
                o_push      = 1'b1;
                o_cmd.kind  = wsp_pkg::KIND_SAMPLE;
                o_cmd.fmt   = r_fmt;
                o_cmd.word  = asm_next;
                o_cmd.chan  = r_ch;
                o_cmd.frame = r_fr;
                o_cmd.eoa   = ch_wrap && fr_end;
            end else if (i_last_byte && (after_state == wsp_pkg::FR_RIFF
                         || after_state == wsp_pkg::FR_SUBHDR
                         || after_state == wsp_pkg::FR_FMT
                         || after_state == wsp_pkg::FR_SKIP)) begin
                o_push    = 1'b1;
                o_cmd.err = wsp_pkg::ERR_TRUNCATED;
            end
        end
    end

    always_comb begin
        n_pos       = r_pos;
        n_tag       = r_tag;
        n_len       = r_len;
        n_coding    = r_coding;
        n_chan      = r_chan;
        n_rate      = r_rate;
        n_bits      = r_bits;
        n_frames    = r_frames;
        n_fr        = r_fr;
        n_ch        = r_ch;
        n_asm       = r_asm;
        n_fmt       = r_fmt;
        n_bpf       = r_bpf;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dcnt      = r_dcnt;
        n_last_pend = r_last_pend;
        if (r_state == wsp_pkg::FR_DIV) begin
            if (!div_done) begin
                n_rem  = ge ? 29'(rem2 - {1'b0, r_bpf}) : rem2[28:0];
                n_quo  = {r_quo[30:0], ge};
                n_dcnt = r_dcnt + 6'd1;
            end else begin
                n_frames = r_quo[30:0];
                n_pos    = 32'd0;
                n_fr     = 31'd0;
                n_ch     = 16'd0;
            end
        end else if (acc) begin
            n_coding = e_coding;
            n_chan   = e_chan;
            n_rate   = e_rate;
            n_bits   = e_bits;
            case (e_state)
                wsp_pkg::FR_RIFF: begin
                    if (!bad_tag) begin
                        n_pos = (e_pos == 32'd11) ? 32'd0 : e_pos + 32'd1;
                    end
                end
                wsp_pkg::FR_SUBHDR: begin
                    n_pos = e_pos + 32'd1;
                    if (e_pos == 32'd0) begin
                        n_tag = {24'd0, i_data_byte};
                        n_len = 32'd0;
                    end else if (e_pos < 32'd4) begin
                        n_tag = {r_tag[23:0], i_data_byte};
                    end else begin
                        n_len = r_len | byte_sh;
                    end
                    if (hdr_done) begin
                        n_pos = 32'd0;
                        if (r_tag == wsp_pkg::TAG_FMT) begin
                            if (full_len >= 32'd16) begin
                                n_coding = 16'd0;
                                n_chan   = 16'd0;
                                n_rate   = 32'd0;
                                n_bits   = 16'd0;
                            end
                        end else if (r_tag == wsp_pkg::TAG_DATA) begin
                            n_bpf       = bpf;
                            n_quo       = full_len;
                            n_rem       = 29'd0;
                            n_dcnt      = 6'd0;
                            n_fmt       = fmt_sel;
                            n_last_pend = i_last_byte;
                        end else begin
                            n_pos = full_len;
                        end
                    end
                end
                wsp_pkg::FR_FMT: begin
                    n_pos = e_pos + 32'd1;
                    if (e_pos < 32'd2) begin
                        n_coding = r_coding | byte_sh[15:0];
                    end else if (e_pos < 32'd4) begin
                        n_chan = r_chan | byte_sh[31:16];
                    end else if (e_pos < 32'd8) begin
                        n_rate = r_rate | byte_sh;
                    end else if (e_pos == 32'd14 || e_pos == 32'd15) begin
                        n_bits = r_bits | byte_sh[31:16];
                    end
                    if (e_pos == 32'd15) begin
                        n_pos = r_len - 32'd16;
                    end
                end
                wsp_pkg::FR_SKIP: begin
                    if (e_pos != 32'd0) begin
                        n_pos = e_pos - 32'd1;
                    end
                end
                wsp_pkg::FR_DATA: begin
                    n_asm = asm_next;
                    n_pos = samp_done ? 32'd0 : e_pos + 32'd1;
                    if (samp_done) begin
                        n_ch = ch_wrap ? 16'd0 : r_ch + 16'd1;
                        if (ch_wrap) begin
                            n_fr = r_fr + 31'd1;
                        end
                    end
                end
                default: n_pos = r_pos;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wsp_pkg::FR_RIFF;
            r_pos       <= '0;
            r_tag       <= '0;
            r_len       <= '0;
            r_coding    <= '0;
            r_chan      <= '0;
            r_rate      <= '0;
            r_bits      <= '0;
            r_frames    <= '0;
            r_fr        <= '0;
            r_ch        <= '0;
            r_asm       <= '0;
            r_fmt       <= wsp_pkg::FMT_INT16;
            r_dcnt      <= '0;
            r_last_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_tag       <= n_tag;
            r_len       <= n_len;
            r_coding    <= n_coding;
            r_chan      <= n_chan;
            r_rate      <= n_rate;
            r_bits      <= n_bits;
            r_frames    <= n_frames;
            r_fr        <= n_fr;
            r_ch        <= n_ch;
            r_asm       <= n_asm;
            r_fmt       <= n_fmt;
            r_dcnt      <= n_dcnt;
            r_last_pend <= n_last_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bpf <= n_bpf;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

endmodule
`default_nettype wire

// ----- sv/wsp_queue.sv -----
// Short command queue between the parser and the sample converter.
`timescale 1ns / 1ps
`default_nettype none
module wsp_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wsp_pkg::t_cmd      i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output wsp_pkg::t_cmd      o_cmd,
    output logic               o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wsp_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- sv/wsp_back.sv -----
// Result stage: integer to single conversion by serial normalization and output register.
`timescale 1ns / 1ps
`default_nettype none
module wsp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    output logic               o_pop,
    input  wsp_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [1:0]         o_result_kind,
    output logic [31:0]        o_sample_bits,
    output logic [15:0]        o_channel_index,
    output logic [30:0]        o_frame_index,
    output logic               o_end_of_audio,
    output logic [31:0]        o_rate_hz,
    output logic [15:0]        o_channel_count,
    output logic [1:0]         o_sample_format,
    output logic [30:0]        o_frame_total,
    output logic [2:0]         o_error_code
);

    wsp_pkg::t_back_state r_state, n_state;
    wsp_pkg::t_cmd        r_cmd;
    logic [23:0]          r_mag;
    logic [7:0]           r_exp;
    logic                 r_sign;
    logic                 r_ovalid;
    wsp_pkg::t_cmd        r_out;

    logic        out_free;
    logic        is_int;
    logic [24:0] sval;
    logic [24:0] smag;
    logic        mag_zero;
    logic        load_direct;
    logic        load_norm;
    logic        start_norm;
    wsp_pkg::t_cmd out_val;

    assign out_free = !r_ovalid || i_ready;
    assign is_int   = (i_cmd.kind == wsp_pkg::KIND_SAMPLE)
                      && (i_cmd.fmt != wsp_pkg::FMT_FLOAT32);
    assign sval     = (i_cmd.fmt == wsp_pkg::FMT_INT16)
                      ? {{9{i_cmd.word[15]}}, i_cmd.word[15:0]}
                      : {i_cmd.word[23], i_cmd.word[23:0]};
    assign smag     = sval[24] ? (25'd0 - sval) : sval;
    assign mag_zero = (smag[23:0] == 24'd0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            wsp_pkg::BK_IDLE: begin
                if (!i_empty && out_free && is_int && !mag_zero) begin
                    n_state = wsp_pkg::BK_NORM;
                end
            end
            wsp_pkg::BK_NORM: begin
                if (r_mag[23] && out_free) begin
                    n_state = wsp_pkg::BK_IDLE;
                end
            end
            default: n_state = wsp_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        load_direct = 1'b0;
        load_norm   = 1'b0;
        start_norm  = 1'b0;
        out_val     = i_cmd;
        case (r_state)
            wsp_pkg::BK_IDLE: begin
                o_pop       = !i_empty && out_free;
                start_norm  = o_pop && is_int && !mag_zero;
                load_direct = o_pop && !start_norm;
                if (is_int) begin
                    out_val.word = 32'd0;
                end
            end
            wsp_pkg::BK_NORM: begin
                load_norm    = r_mag[23] && out_free;
                out_val      = r_cmd;
                out_val.word = {r_sign, r_exp, r_mag[22:0]};
            end
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wsp_pkg::BK_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_direct || load_norm) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_direct || load_norm) begin
            r_out <= out_val;
        end
        if (start_norm) begin
            r_cmd  <= i_cmd;
            r_mag  <= smag[23:0];
            r_sign <= sval[24];
            r_exp  <= (i_cmd.fmt == wsp_pkg::FMT_INT16) ? wsp_pkg::EXP_INT16
                                                        : wsp_pkg::EXP_INT24;
        end else if (r_state == wsp_pkg::BK_NORM && !r_mag[23]) begin
            r_mag <= {r_mag[22:0], 1'b0};
            r_exp <= r_exp - 8'd1;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_result_kind   = r_out.kind;
    assign o_sample_bits   = r_out.word;
    assign o_channel_index = r_out.chan;
    assign o_frame_index   = r_out.frame;
    assign o_end_of_audio  = r_out.eoa;
    assign o_rate_hz       = r_out.rate;
    assign o_channel_count = r_out.chan_count;
    assign o_sample_format = (r_out.kind == wsp_pkg::KIND_FORMAT) ? r_out.fmt : 2'd0;
    assign o_frame_total   = r_out.total;
    assign o_error_code    = r_out.err;

endmodule
`default_nettype wire

// ----- sv/wav_stream_parser_pcm_to_float_core.sv -----
// Top level of the WAV stream parser: byte parser, command queue and result stage.
// Header and skip bytes are taken one per cycle while the queue is not full; after the last data
// chunk header byte, input is held while the serial divider forms the frame count.
// A nonzero int16 or int24 sample is normalized in the result stage, one normalizing shift
// per cycle; float words, zero samples and reports load the output register directly.
// Synchronous active-low reset clears all control state; the parser then waits for RIFF.
`timescale 1ns / 1ps
`default_nettype none
module wav_stream_parser_pcm_to_float_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_result_kind,
    output logic [31:0]      o_sample_bits,
    output logic [15:0]      o_channel_index,
    output logic [30:0]      o_frame_index,
    output logic             o_end_of_audio,
    output logic [31:0]      o_rate_hz,
    output logic [15:0]      o_channel_count,
    output logic [1:0]       o_sample_format,
    output logic [30:0]      o_frame_total,
    output logic [2:0]       o_error_code
);

    logic          push;
    logic          full;
    logic          pop;
    logic          empty;
    wsp_pkg::t_cmd push_cmd;
    wsp_pkg::t_cmd pop_cmd;

    wsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .i_full       (full)
    );

    wsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (empty)
    );

    wsp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .o_pop           (pop),
        .i_cmd           (pop_cmd),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_sample_bits   (o_sample_bits),
        .o_channel_index (o_channel_index),
        .o_frame_index   (o_frame_index),
        .o_end_of_audio  (o_end_of_audio),
        .o_rate_hz       (o_rate_hz),
        .o_channel_count (o_channel_count),
        .o_sample_format (o_sample_format),
        .o_frame_total   (o_frame_total),
        .o_error_code    (o_error_code)
    );

endmodule
`default_nettype wire

// ----- sv/wsp_checker.sv -----
// Port-level assertions for the WAV stream parser and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module wsp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_result_kind,
    input wire logic [31:0] o_sample_bits,
    input wire logic [31:0] o_rate_hz,
    input wire logic [30:0] o_frame_total,
    input wire logic [2:0]  o_error_code
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_bits))
        else $error("Output transaction changed before it was taken.");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_result_kind != 2'd3)
        else $error("Illegal result kind.");

    a_sample_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == wsp_pkg::KIND_SAMPLE
        |-> o_rate_hz == 32'd0 && o_frame_total == 31'd0 && o_error_code == 3'd0)
        else $error("Sample carries report fields.");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == wsp_pkg::KIND_ERROR
        |-> o_error_code <= wsp_pkg::ERR_TRUNCATED && o_sample_bits == 32'd0)
        else $error("Malformed error result.");

endmodule

bind wav_stream_parser_pcm_to_float_core wsp_checker u_wsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_result_kind (o_result_kind),
    .o_sample_bits (o_sample_bits),
    .o_rate_hz     (o_rate_hz),
    .o_frame_total (o_frame_total),
    .o_error_code  (o_error_code)
);
`default_nettype wire
